// ----- rtl/core/buddy_page_allocator_macros.svh -----
// Assertion macros shared by the buddy page allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/bpa_pkg.sv -----
// Types and constants of the buddy page allocator.
package bpa_pkg;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_FREE    = 1'b1;

  localparam logic [2:0] TAG_FREE   = 3'd0;
  localparam logic [2:0] TAG_TAIL   = 3'd1;
  localparam logic [2:0] KIND_MIN   = 3'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBLK   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_SRCH,
    S_A_UNL,
    S_A_SPL1,
    S_A_SPL2,
    S_A_TAG,
    S_F_RD,
    S_F_EV,
    S_M_RD,
    S_M_EV,
    S_F_PUSH1,
    S_F_PUSH2,
    S_DONE
  } bpa_state_t;

endpackage

// ----- rtl/core/bpa_if.sv -----
// Request and result channel interfaces of the buddy page allocator.
interface bpa_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] block_order;
  logic [2:0] owner_kind;
  logic [9:0] page_index;
  modport source (output valid, opcode, block_order, owner_kind, page_index, input ready);
  modport sink   (input valid, opcode, block_order, owner_kind, page_index, output ready);
endinterface

interface bpa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  result_page;
  logic [3:0]  result_order;
  logic [10:0] free_blocks_at_order;
  modport source (output valid, status, result_page, result_order, free_blocks_at_order,
                  input ready);
  modport sink   (input valid, status, result_page, result_order, free_blocks_at_order,
                  output ready);
endinterface

// ----- rtl/core/buddy_page_allocator.sv -----
// Buddy page allocator: sequencer around page-state and link memories.
// Allocate searches upward for a non-empty order, unlinks its head, then splits down with
// two split steps per order and tags the block; a failed search ends past MAX_ORDER. Free
// reads and checks the page, reads and checks the buddy per merge level, then pushes the block.
// After reset a clearing pass over all NUM_PAGES pages builds the memories; no request is taken then.
// A finished result waits in an output register while the next request may be accepted.
`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_ORDER = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch
);

  // Page index width, link width (one extra code for "no page"), order index width.
  localparam int AW   = $clog2(NUM_PAGES);
  localparam int PW   = $clog2(NUM_PAGES + 1);
  localparam int LW   = (MAX_ORDER < 1) ? 1 : $clog2(MAX_ORDER + 1);
  localparam int OW   = 5;
  localparam int BLK  = 1 << MAX_ORDER;
  localparam int NBLK = NUM_PAGES >> MAX_ORDER;
  localparam logic [PW-1:0] NONE = PW'(NUM_PAGES);
  localparam logic [OW-1:0] MO   = OW'(MAX_ORDER);

  // Per-page memories. Each has one write port and shares the read address.
  logic [2:0]    tag_mem [NUM_PAGES];
  logic [3:0]    ord_mem [NUM_PAGES];
  logic [PW-1:0] nxt_mem [NUM_PAGES];
  logic [PW-1:0] prv_mem [NUM_PAGES];

  logic [AW-1:0] rd_addr;
  logic [2:0]    rd_tag_q;
  logic [3:0]    rd_ord_q;
  logic [PW-1:0] rd_nxt_q;
  logic [PW-1:0] rd_prv_q;

  logic          tag_we, ord_we, nxt_we, prv_we;
  logic [AW-1:0] tag_wa, ord_wa, nxt_wa, prv_wa;
  logic [2:0]    tag_wd;
  logic [3:0]    ord_wd;
  logic [PW-1:0] nxt_wd, prv_wd;

  // Per-order list heads, tails and counts, written at order o_r only.
  logic [PW-1:0] head_r [MAX_ORDER+1];
  logic [PW-1:0] tail_r [MAX_ORDER+1];
  logic [PW-1:0] cnt_r  [MAX_ORDER+1];
  logic          hd_we, tl_we, cnt_we;
  logic [PW-1:0] hd_wd, tl_wd, cnt_wd;

  bpa_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [3:0]    ord_r, ord_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [9:0]    idx_r, idx_nxt;
  logic [PW-1:0] p_r, p_nxt, b_r, b_nxt, t_r, t_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic [1:0]    rst_st_r, rst_st_nxt;
  logic [3:0]    res_ord_r, res_ord_nxt;
  logic          fcz_r, fcz_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [9:0]    out_pg_r, out_pg_nxt;
  logic [3:0]    out_ord_r, out_ord_nxt;
  logic [10:0]   out_fc_r, out_fc_nxt;

  // Values looked at in several states.
  logic [LW-1:0] oi;
  logic [PW-1:0] head_o, tail_o, cnt_o;
  logic [PW-1:0] bud;
  logic          idx_bad;
  logic          out_free;
  logic          buddy_ok;

  assign oi       = o_r[LW-1:0];
  assign head_o   = head_r[oi];
  assign tail_o   = tail_r[oi];
  assign cnt_o    = cnt_r[oi];
  assign bud      = p_r ^ (PW'(1) << o_r);
  assign idx_bad  = 32'(idx_r) >= 32'(NUM_PAGES);
  assign out_free = !out_valid_r || out_ch.ready;
  assign buddy_ok = (rd_tag_q == TAG_FREE) && (OW'(rd_ord_q) == o_r);

  assign in_ch.ready                 = (state_r == S_IDLE);
  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_st_r;
  assign out_ch.result_page          = out_pg_r;
  assign out_ch.result_order         = out_ord_r;
  assign out_ch.free_blocks_at_order = out_fc_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (clr_r == AW'(NUM_PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_ch.valid) state_nxt = (in_ch.opcode == OP_FREE) ? S_F_RD : S_A_SRCH;
      end
      S_A_SRCH: begin
        if (OW'(ord_r) > MO || o_r > MO) state_nxt = S_DONE;
        else if (head_o != NONE)          state_nxt = S_A_UNL;
      end
      S_A_UNL:   state_nxt = (o_r > OW'(ord_r)) ? S_A_SPL1 : S_A_TAG;
      S_A_SPL1:  state_nxt = S_A_SPL2;
      S_A_SPL2:  state_nxt = (o_r > OW'(ord_r)) ? S_A_SPL1 : S_A_TAG;
      S_A_TAG:   state_nxt = S_DONE;
      S_F_RD:    state_nxt = idx_bad ? S_DONE : S_F_EV;
      S_F_EV: begin
        if (rd_tag_q == TAG_FREE || rd_tag_q == TAG_TAIL) state_nxt = S_DONE;
        else                                                 state_nxt = S_M_RD;
      end
      S_M_RD: begin
        if (o_r >= MO || bud >= NONE) state_nxt = S_F_PUSH1;
        else                          state_nxt = S_M_EV;
      end
      S_M_EV:    state_nxt = buddy_ok ? S_M_RD : S_F_PUSH1;
      S_F_PUSH1: state_nxt = S_F_PUSH2;
      S_F_PUSH2: state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    logic [31:0] ci;
    logic [31:0] cb;
    logic [PW-1:0] lo, hi;

    ci = 32'(clr_r);
    cb = ci >> MAX_ORDER;
    lo = (p_r < b_r) ? p_r : b_r;
    hi = (p_r < b_r) ? b_r : p_r;

    rd_addr = '0;
    tag_we = 1'b0; tag_wa = '0; tag_wd = TAG_TAIL;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NONE;
    prv_we = 1'b0; prv_wa = '0; prv_wd = NONE;
    hd_we  = 1'b0; hd_wd  = NONE;
    tl_we  = 1'b0; tl_wd  = NONE;
    cnt_we = 1'b0; cnt_wd = cnt_o;

    clr_nxt     = clr_r;
    ord_nxt     = ord_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    p_nxt       = p_r;
    b_nxt       = b_r;
    t_nxt       = t_r;
    o_nxt       = o_r;
    rst_st_nxt  = rst_st_r;
    res_ord_nxt = res_ord_r;
    fcz_nxt     = fcz_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_pg_nxt    = out_pg_r;
    out_ord_nxt   = out_ord_r;
    out_fc_nxt    = out_fc_r;

    unique case (state_r)
      S_CLR: begin
        // Top-order heads of whole blocks are free and chained in ascending order.
        tag_we = 1'b1; tag_wa = clr_r;
        ord_we = 1'b1; ord_wa = clr_r;
        nxt_we = 1'b1; nxt_wa = clr_r;
        prv_we = 1'b1; prv_wa = clr_r;
        if ((ci & 32'(BLK - 1)) == 32'd0 && cb < 32'(NBLK)) begin
          tag_wd = TAG_FREE;
          ord_wd = 4'(MAX_ORDER);
          nxt_wd = (cb + 32'd1 < 32'(NBLK)) ? PW'(ci + 32'(BLK)) : NONE;
          prv_wd = (cb > 32'd0) ? PW'(ci - 32'(BLK)) : NONE;
        end
        clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          ord_nxt  = in_ch.block_order;
          kind_nxt = in_ch.owner_kind;
          idx_nxt  = in_ch.page_index;
          o_nxt    = OW'(in_ch.block_order);
        end
      end
      S_A_SRCH: begin
        if (OW'(ord_r) > MO) begin
          rst_st_nxt = ST_NOBLK; p_nxt = '0; res_ord_nxt = ord_r; fcz_nxt = 1'b1;
        end else if (o_r > MO) begin
          rst_st_nxt = ST_NOBLK; p_nxt = '0; res_ord_nxt = ord_r; fcz_nxt = 1'b0;
          o_nxt = OW'(ord_r);
        end else if (head_o == NONE) begin
          o_nxt = o_r + OW'(1);
        end else begin
          p_nxt   = head_o;
          rd_addr = head_o[AW-1:0];
        end
      end
      S_A_UNL: begin
        // Unlink the popped head; its own links go stale and are never read again.
        if (rd_prv_q != NONE) begin
          nxt_we = 1'b1; nxt_wa = rd_prv_q[AW-1:0]; nxt_wd = rd_nxt_q;
        end else begin
          hd_we = 1'b1; hd_wd = rd_nxt_q;
        end
        if (rd_nxt_q != NONE) begin
          prv_we = 1'b1; prv_wa = rd_nxt_q[AW-1:0]; prv_wd = rd_prv_q;
        end else begin
          tl_we = 1'b1; tl_wd = rd_prv_q;
        end
        cnt_we = 1'b1; cnt_wd = cnt_o - PW'(1);
        if (o_r > OW'(ord_r)) o_nxt = o_r - OW'(1);
      end
      S_A_SPL1: begin
        // Upper half of the block goes to the back of this order's list.
        b_nxt  = p_r + (PW'(1) << o_r);
        t_nxt  = tail_o;
        tag_we = 1'b1; tag_wa = b_nxt[AW-1:0]; tag_wd = TAG_FREE;
        ord_we = 1'b1; ord_wa = b_nxt[AW-1:0]; ord_wd = 4'(o_r);
        nxt_we = 1'b1; nxt_wa = b_nxt[AW-1:0]; nxt_wd = NONE;
        prv_we = 1'b1; prv_wa = b_nxt[AW-1:0]; prv_wd = tail_o;
        if (tail_o == NONE) begin
          hd_we = 1'b1; hd_wd = b_nxt;
        end
        tl_we  = 1'b1; tl_wd  = b_nxt;
        cnt_we = 1'b1; cnt_wd = cnt_o + PW'(1);
      end
      S_A_SPL2: begin
        if (t_r != NONE) begin
          nxt_we = 1'b1; nxt_wa = t_r[AW-1:0]; nxt_wd = b_r;
        end
        if (o_r > OW'(ord_r)) o_nxt = o_r - OW'(1);
      end
      S_A_TAG: begin
        tag_we = 1'b1; tag_wa = p_r[AW-1:0];
        tag_wd = (kind_r < KIND_MIN) ? KIND_MIN : kind_r;
        ord_we = 1'b1; ord_wa = p_r[AW-1:0]; ord_wd = ord_r;
        rst_st_nxt = ST_OK; res_ord_nxt = ord_r; fcz_nxt = 1'b0;
      end
      S_F_RD: begin
        rst_st_nxt = ST_BADFREE; p_nxt = PW'(idx_r); res_ord_nxt = '0; fcz_nxt = 1'b1;
        rd_addr = AW'(idx_r);
      end
      S_F_EV: begin
        if (!(rd_tag_q == TAG_FREE || rd_tag_q == TAG_TAIL)) begin
          o_nxt  = (OW'(rd_ord_q) > MO) ? MO : OW'(rd_ord_q);
          tag_we = 1'b1; tag_wa = AW'(idx_r); tag_wd = TAG_FREE;
        end
      end
      S_M_RD: begin
        b_nxt   = bud;
        rd_addr = bud[AW-1:0];
      end
      S_M_EV: begin
        if (buddy_ok) begin
          // Take the buddy off its list and fold the upper half into the lower head.
          if (rd_prv_q != NONE) begin
            nxt_we = 1'b1; nxt_wa = rd_prv_q[AW-1:0]; nxt_wd = rd_nxt_q;
          end else begin
            hd_we = 1'b1; hd_wd = rd_nxt_q;
          end
          if (rd_nxt_q != NONE) begin
            prv_we = 1'b1; prv_wa = rd_nxt_q[AW-1:0]; prv_wd = rd_prv_q;
          end else begin
            tl_we = 1'b1; tl_wd = rd_prv_q;
          end
          cnt_we = 1'b1; cnt_wd = cnt_o - PW'(1);
          tag_we = 1'b1; tag_wa = hi[AW-1:0]; tag_wd = TAG_TAIL;
          ord_we = 1'b1; ord_wa = hi[AW-1:0]; ord_wd = '0;
          p_nxt  = lo;
          o_nxt  = o_r + OW'(1);
        end
      end
      S_F_PUSH1: begin
        t_nxt  = head_o;
        ord_we = 1'b1; ord_wa = p_r[AW-1:0]; ord_wd = 4'(o_r);
        nxt_we = 1'b1; nxt_wa = p_r[AW-1:0]; nxt_wd = head_o;
        prv_we = 1'b1; prv_wa = p_r[AW-1:0]; prv_wd = NONE;
        hd_we  = 1'b1; hd_wd  = p_r;
        if (head_o == NONE) begin
          tl_we = 1'b1; tl_wd = p_r;
        end
        cnt_we = 1'b1; cnt_wd = cnt_o + PW'(1);
      end
      S_F_PUSH2: begin
        if (t_r != NONE) begin
          prv_we = 1'b1; prv_wa = t_r[AW-1:0]; prv_wd = p_r;
        end
        rst_st_nxt = ST_OK; res_ord_nxt = 4'(o_r); fcz_nxt = 1'b0;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = rst_st_r;
          out_pg_nxt    = 10'(p_r);
          out_ord_nxt   = res_ord_r;
          out_fc_nxt    = fcz_r ? 11'd0 : 11'(cnt_o);
        end
      end
      default: ;
    endcase
  end

  // Page memories.
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    rd_tag_q <= tag_mem[rd_addr];
    rd_ord_q <= ord_mem[rd_addr];
    rd_nxt_q <= nxt_mem[rd_addr];
    rd_prv_q <= prv_mem[rd_addr];
  end

  // Free list descriptors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_r[i] <= NONE;
        tail_r[i] <= NONE;
        cnt_r[i]  <= '0;
      end
      if (NBLK > 0) begin
        head_r[MAX_ORDER] <= '0;
        tail_r[MAX_ORDER] <= PW'((NBLK - 1) * BLK);
      end
      cnt_r[MAX_ORDER] <= PW'(NBLK);
    end else begin
      if (hd_we)  head_r[oi] <= hd_wd;
      if (tl_we)  tail_r[oi] <= tl_wd;
      if (cnt_we) cnt_r[oi]  <= cnt_wd;
    end
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ord_r     <= ord_nxt;
    kind_r    <= kind_nxt;
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    b_r       <= b_nxt;
    t_r       <= t_nxt;
    o_r       <= o_nxt;
    rst_st_r  <= rst_st_nxt;
    res_ord_r <= res_ord_nxt;
    fcz_r     <= fcz_nxt;
    out_st_r  <= out_st_nxt;
    out_pg_r  <= out_pg_nxt;
    out_ord_r <= out_ord_nxt;
    out_fc_r  <= out_fc_nxt;
  end

  `BPA_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_A_SRCH || state_r == S_F_RD, "accepted transaction did not start")
  `BPA_ASSERT_NEXT(a_done_posts, state_r == S_DONE && out_free, out_valid_r, "finished transaction not posted")
  `BPA_ASSERT_NOW(a_merge_order, state_r == S_M_EV, o_r < MO, "merge beyond top order")
  `BPA_ASSERT_NOW(a_buddy_range, state_r == S_M_EV, b_r < NONE, "buddy outside page range")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the buddy page allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int NUM_PAGES = 1024;
  localparam int MAX_ORDER = 10;
  localparam int NIL = NUM_PAGES;
  localparam int RANDOM_ITEMS = 930;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  page;
    logic [3:0]  order;
    logic [10:0] free_cnt;
  } alloc_result_t;

  typedef struct {
    logic        opcode;
    logic [3:0]  block_order;
    logic [2:0]  owner_kind;
    logic [9:0]  page_index;
    bit          known;
    logic [1:0]  status;
    logic [9:0]  page;
    logic [3:0]  order;
    logic [10:0] free_cnt;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned sent_cnt = 0;

  bpa_in_if  in_ch ();
  bpa_out_if out_ch ();

  buddy_page_allocator #(
    .NUM_PAGES(NUM_PAGES),
    .MAX_ORDER(MAX_ORDER)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the page memories and the per-order free lists.
  logic [2:0] tag_mem[NUM_PAGES];
  int         order_mem[NUM_PAGES];
  int         nxt[NUM_PAGES];
  int         prv[NUM_PAGES];
  int         head[MAX_ORDER + 1];
  int         tail[MAX_ORDER + 1];
  int         count[MAX_ORDER + 1];

  alloc_result_t pending_results[$];
  // Heads currently owned, so random frees can target real blocks.
  int owned_heads[$];

  function automatic void list_unlink(int o, int p);
    int n;
    int v;
    n = nxt[p];
    v = prv[p];
    if (v != NIL) nxt[v] = n; else head[o] = n;
    if (n != NIL) prv[n] = v; else tail[o] = v;
    nxt[p] = NIL;
    prv[p] = NIL;
    count[o]--;
  endfunction

  function automatic void list_push(int o, int p, bit at_front);
    if (at_front) begin
      prv[p] = NIL;
      nxt[p] = head[o];
      if (head[o] != NIL) prv[head[o]] = p; else tail[o] = p;
      head[o] = p;
    end else begin
      nxt[p] = NIL;
      prv[p] = tail[o];
      if (tail[o] != NIL) nxt[tail[o]] = p; else head[o] = p;
      tail[o] = p;
    end
    count[o]++;
  endfunction

  function automatic void shadow_reset();
    for (int o = 0; o <= MAX_ORDER; o++) begin
      head[o] = NIL;
      tail[o] = NIL;
      count[o] = 0;
    end
    for (int i = 0; i < NUM_PAGES; i++) begin
      tag_mem[i] = TAG_TAIL;
      order_mem[i] = 0;
      nxt[i] = NIL;
      prv[i] = NIL;
    end
    for (int i = 0; i < (NUM_PAGES >> MAX_ORDER); i++) begin
      tag_mem[i << MAX_ORDER] = TAG_FREE;
      order_mem[i << MAX_ORDER] = MAX_ORDER;
      list_push(MAX_ORDER, i << MAX_ORDER, 1'b0);
    end
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic alloc_result_t allocator_step(logic op, int ord, logic [2:0] kind, int idx);
    alloc_result_t r;
    int o;
    int p;
    int b;
    r = '{ST_NOBLK, 10'd0, ord[3:0], 11'd0};
    if (op == OP_ALLOC) begin
      if (ord > MAX_ORDER) return r;
      o = ord;
      while (o <= MAX_ORDER && head[o] == NIL) o++;
      if (o > MAX_ORDER) begin
        r.free_cnt = count[ord];
        return r;
      end
      p = head[o];
      list_unlink(o, p);
      // Split down: each upper half joins the back of the next lower list.
      while (o > ord) begin
        o--;
        b = p + (1 << o);
        tag_mem[b] = TAG_FREE;
        order_mem[b] = o;
        list_push(o, b, 1'b0);
      end
      tag_mem[p] = (kind < KIND_MIN) ? KIND_MIN : kind;
      order_mem[p] = ord;
      r = '{ST_OK, p[9:0], ord[3:0], count[ord][10:0]};
    end else begin
      if (idx >= NUM_PAGES || tag_mem[idx] == TAG_FREE || tag_mem[idx] == TAG_TAIL) begin
        return '{ST_BADFREE, idx[9:0], 4'd0, 11'd0};
      end
      p = idx;
      o = (order_mem[p] > MAX_ORDER) ? MAX_ORDER : order_mem[p];
      tag_mem[p] = TAG_FREE;
      // Merge upward while the buddy is a free head of the same order.
      while (o < MAX_ORDER) begin
        b = p ^ (1 << o);
        if (b >= NUM_PAGES || tag_mem[b] != TAG_FREE || order_mem[b] != o) break;
        list_unlink(o, b);
        tag_mem[(p < b) ? b : p] = TAG_TAIL;
        order_mem[(p < b) ? b : p] = 0;
        p = (p < b) ? p : b;
        o++;
        tag_mem[p] = TAG_FREE;
      end
      order_mem[p] = o;
      list_push(o, p, 1'b1);
      r = '{ST_OK, p[9:0], o[3:0], count[o][10:0]};
    end
    return r;
  endfunction

  // Random gaps on both sides, except for a long stretch in the middle of the run.
  function automatic bit take_gap();
    if (sent_cnt >= 400 && sent_cnt < 560) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  // Drives one request; the expectation is queued at the edge that accepts it.
  task automatic send_request(plan_row_t row);
    alloc_result_t predicted;
    while (take_gap()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = row.opcode;
    in_ch.block_order = row.block_order;
    in_ch.owner_kind = row.owner_kind;
    in_ch.page_index = row.page_index;
    do @(posedge clk); while (!in_ch.ready);
    predicted = allocator_step(row.opcode, row.block_order, row.owner_kind, row.page_index);
    if (predicted.status == ST_OK) begin
      if (row.opcode == OP_ALLOC) begin
        owned_heads.push_back(predicted.page);
      end else begin
        foreach (owned_heads[i]) begin
          if (owned_heads[i] == row.page_index) begin
            owned_heads.delete(i);
            break;
          end
        end
      end
    end
    if (row.known) pending_results.push_back('{row.status, row.page, row.order, row.free_cnt});
    else pending_results.push_back(predicted);
    sent_cnt++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Directed opening. Known rows follow from the single free top-order block after reset.
  plan_row_t opening_plan[] = '{
    '{OP_ALLOC, 4'd11, 3'd2, 10'd0,    1, ST_NOBLK,   10'd0,    4'd11, 11'd0},
    '{OP_ALLOC, 4'd15, 3'd7, 10'd0,    1, ST_NOBLK,   10'd0,    4'd15, 11'd0},
    '{OP_FREE,  4'd0,  3'd2, 10'd1023, 1, ST_BADFREE, 10'd1023, 4'd0,  11'd0},
    '{OP_FREE,  4'd0,  3'd2, 10'd0,    1, ST_BADFREE, 10'd0,    4'd0,  11'd0},
    '{OP_ALLOC, 4'd10, 3'd7, 10'd0,    1, ST_OK,      10'd0,    4'd10, 11'd0},
    '{OP_ALLOC, 4'd0,  3'd3, 10'd0,    1, ST_NOBLK,   10'd0,    4'd0,  11'd0},
    '{OP_FREE,  4'd10, 3'd0, 10'd0,    1, ST_OK,      10'd0,    4'd10, 11'd1},
    '{OP_ALLOC, 4'd0,  3'd0, 10'd0,    0, 0, 0, 0, 0},
    '{OP_ALLOC, 4'd0,  3'd1, 10'd0,    0, 0, 0, 0, 0},
    '{OP_ALLOC, 4'd1,  3'd5, 10'd0,    0, 0, 0, 0, 0},
    '{OP_ALLOC, 4'd4,  3'd6, 10'd0,    0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd512,  1, ST_BADFREE, 10'd512,  4'd0,  11'd0},
    '{OP_FREE,  4'd0,  3'd2, 10'd1,    0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd0,    0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd2,    0, 0, 0, 0, 0},
    '{OP_ALLOC, 4'd9,  3'd4, 10'd0,    0, 0, 0, 0, 0},
    '{OP_ALLOC, 4'd9,  3'd4, 10'd0,    0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd16,   0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd4,    0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd512,  0, 0, 0, 0, 0},
    '{OP_FREE,  4'd0,  3'd2, 10'd0,    0, 0, 0, 0, 0}
  };

  // The sink stalls at random, outside the quiet stretch.
  always @(negedge clk) begin
    out_ch.ready <= !take_gap();
  end

  // Compare every result transaction against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d page=%0d order=%0d free=%0d", $time,
                 out_ch.status, out_ch.result_page, out_ch.result_order,
                 out_ch.free_blocks_at_order);
        error_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          error_cnt++;
        end
        if (out_ch.result_page !== want.page) begin
          $display("%0t: result_page expected %0d actual %0d", $time, want.page,
                   out_ch.result_page);
          error_cnt++;
        end
        if (out_ch.result_order !== want.order) begin
          $display("%0t: result_order expected %0d actual %0d", $time, want.order,
                   out_ch.result_order);
          error_cnt++;
        end
        if (out_ch.free_blocks_at_order !== want.free_cnt) begin
          $display("%0t: free_blocks_at_order expected %0d actual %0d", $time, want.free_cnt,
                   out_ch.free_blocks_at_order);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    int wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ALLOC;
    in_ch.block_order = '0;
    in_ch.owner_kind = KIND_MIN;
    in_ch.page_index = '0;
    out_ch.ready = 1'b0;
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (opening_plan[i]) send_request(opening_plan[i]);

    // Mostly well-formed traffic: allocations of small orders and frees of owned blocks,
    // with oversized orders and frees of arbitrary pages mixed in as noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int pick;
      row = '{OP_ALLOC, 4'($urandom_range(4)), 3'($urandom_range(7)), 10'($urandom_range(1023)),
              0, 0, 0, 0, 0};
      pick = $urandom_range(99);
      if (pick < 8) begin
        row.block_order = 4'($urandom_range(15));
      end else if (pick < 14) begin
        row.opcode = OP_FREE;
      end else if (pick < 55 && owned_heads.size() > 0) begin
        row.opcode = OP_FREE;
        row.page_index = 10'(owned_heads[$urandom_range(owned_heads.size() - 1)]);
      end
      send_request(row);
    end

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/buddy_page_allocator.sv
verif/testbench.sv
